### rtl/gcna_pkg.sv
// Package for the grouped complex norm accumulator.
// Holds the default widths, the controller state type and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package gcna_pkg;

  // Default parameter values.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF    = 40;

  // Fixed widths of the cell total and of the shared squaring multiplier.
  localparam int SUM_W  = 63;
  localparam int HALF_W = 32;

  // Four accumulators times four partial products each.
  localparam int SQ_STEPS = 16;
  localparam int CNT_W    = $clog2(SQ_STEPS + 1);

  // Shift codes of a partial product, in units of HALF_W.
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_HALF = 2'd1;
  localparam logic [1:0] SH_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MAG,
    ST_SQ,
    ST_TOTAL
  } gcna_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // register the term products of an accepted request
    logic accum;    // add the products into the four accumulators
    logic mag;      // take magnitudes, clear accumulators, start squaring
    logic sq_step;  // one step of the squaring sequence
    logic total;    // add the group norm into the cell total, emit on cell end
  } gcna_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close_grp;  // the current term closes its group
    logic cell_end;   // the current term closes its cell
    logic sq_done;    // the last partial product is being added
    logic out_free;   // the output register can take a result this cycle
  } gcna_stat_t;

endpackage

### rtl/gcna_ctrl.sv
// Controller state machine for the grouped complex norm accumulator.
// Sequences load, accumulate, squaring and total update; uses gcna_pkg.
// Drives the input ready and the datapath commands.
`timescale 1ns / 1ps

module gcna_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gcna_pkg::gcna_stat_t stat,
  output gcna_pkg::gcna_cmd_t  cmd
);

  gcna_pkg::gcna_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcna_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gcna_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = gcna_pkg::ST_ACC;
        end
      end
      gcna_pkg::ST_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = stat.close_grp ? gcna_pkg::ST_MAG : gcna_pkg::ST_IDLE;
      end
      gcna_pkg::ST_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = gcna_pkg::ST_SQ;
      end
      gcna_pkg::ST_SQ: begin
        cmd.sq_step = 1'b1;
        if (stat.sq_done) begin
          state_nxt = gcna_pkg::ST_TOTAL;
        end
      end
      gcna_pkg::ST_TOTAL: begin
        // A cell end waits until the output register is free.
        if (!stat.cell_end || stat.out_free) begin
          cmd.total = 1'b1;
          state_nxt = gcna_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gcna_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/gcna_dp.sv
// Datapath of the grouped complex norm accumulator: term products, saturating
// accumulators, a shared squaring multiplier, cell total and output register.
// Uses gcna_pkg; driven by gcna_ctrl.
`timescale 1ns / 1ps

module gcna_dp #(
  parameter int SAMPLE_WIDTH = gcna_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = gcna_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gcna_pkg::gcna_cmd_t                cmd,
  output gcna_pkg::gcna_stat_t               stat,
  input  logic signed [SAMPLE_WIDTH-1:0]    den_re,
  input  logic signed [SAMPLE_WIDTH-1:0]    den_im,
  input  logic signed [SAMPLE_WIDTH-1:0]    theta_re,
  input  logic signed [SAMPLE_WIDTH-1:0]    theta_im,
  input  logic signed [SAMPLE_WIDTH-1:0]    phi_re,
  input  logic signed [SAMPLE_WIDTH-1:0]    phi_im,
  input  logic                              group_end,
  input  logic                              cell_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gcna_pkg::SUM_W-1:0]        out_cell_sum,
  output logic                              out_overflow
);

  localparam int PW     = 2 * SAMPLE_WIDTH;
  localparam int NPW    = PW + 1;
  localparam int S_W    = ((ACC_WIDTH > NPW) ? ACC_WIDTH : NPW) + 2;
  localparam int FRAC   = 2 * (SAMPLE_WIDTH - 1);
  localparam int NORM_W = 2 * ACC_WIDTH + 1;
  localparam int TW     = NORM_W + 1;
  localparam int SUM_W  = gcna_pkg::SUM_W;
  localparam int HALF_W = gcna_pkg::HALF_W;
  localparam int CNT_W  = gcna_pkg::CNT_W;

  localparam logic signed [S_W-1:0] AMAX = S_W'({1'b0, {(ACC_WIDTH - 1){1'b1}}});
  localparam logic signed [S_W-1:0] AMIN = ~AMAX;
  localparam logic [TW-1:0]         TMAX = TW'({SUM_W{1'b1}});

  // Term products, second product already carrying its sign.
  logic signed [PW-1:0]        m_dr_tr, m_di_ti, m_dr_ti, m_di_tr;
  logic signed [PW-1:0]        m_dr_pr, m_di_pi, m_dr_pi, m_di_pr;
  logic signed [NPW-1:0]       pa_r [4];
  logic signed [NPW-1:0]       pb_r [4];
  logic                        close_r, cend_r;

  // Accumulators and their next values.
  logic signed [ACC_WIDTH-1:0] acc_r   [4];
  logic signed [ACC_WIDTH-1:0] acc_nxt [4];
  logic [3:0]                  lane_sat;
  logic signed [S_W-1:0]       lane_sum [4];

  // Squaring sequence.
  logic [ACC_WIDTH-1:0]        mag_r [4];
  logic [CNT_W-1:0]            cnt_r;
  logic [ACC_WIDTH-1:0]        mag_sel;
  logic [HALF_W-1:0]           half_a, half_b;
  logic [2*HALF_W-1:0]         mul_w, prod_r;
  logic [1:0]                  sh_r;
  logic                        pv_r;
  logic [NORM_W-1:0]           shifted;
  logic [NORM_W-1:0]           sum_r;

  // Cell total.
  logic [SUM_W-1:0]            total_r;
  logic                        sat_r;
  logic [TW-1:0]               tot_w;
  logic                        tot_sat;
  logic [SUM_W-1:0]            total_new;

  logic                        out_valid_r;
  logic [SUM_W-1:0]            out_sum_r;
  logic                        out_ovf_r;

  // Eight term multipliers working straight from the input ports.
  assign m_dr_tr = PW'(den_re) * PW'(theta_re);
  assign m_di_ti = PW'(den_im) * PW'(theta_im);
  assign m_dr_ti = PW'(den_re) * PW'(theta_im);
  assign m_di_tr = PW'(den_im) * PW'(theta_re);
  assign m_dr_pr = PW'(den_re) * PW'(phi_re);
  assign m_di_pi = PW'(den_im) * PW'(phi_im);
  assign m_dr_pi = PW'(den_re) * PW'(phi_im);
  assign m_di_pr = PW'(den_im) * PW'(phi_re);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pa_r[0] <= NPW'(m_dr_tr);
      pb_r[0] <= -NPW'(m_di_ti);
      pa_r[1] <= NPW'(m_dr_ti);
      pb_r[1] <= NPW'(m_di_tr);
      pa_r[2] <= NPW'(m_dr_pr);
      pb_r[2] <= -NPW'(m_di_pi);
      pa_r[3] <= NPW'(m_dr_pi);
      pb_r[3] <= NPW'(m_di_pr);
    end
  end

  // Group and cell flags of the current term; a cell end also closes the group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_r <= 1'b0;
      cend_r  <= 1'b0;
    end else if (cmd.load) begin
      close_r <= group_end | cell_end;
      cend_r  <= cell_end;
    end
  end

  // Saturating add of both products into each accumulator.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_sum[i] = S_W'(acc_r[i]) + S_W'(pa_r[i]) + S_W'(pb_r[i]);
      if (lane_sum[i] > AMAX) begin
        acc_nxt[i]  = ACC_WIDTH'(AMAX);
        lane_sat[i] = 1'b1;
      end else if (lane_sum[i] < AMIN) begin
        acc_nxt[i]  = ACC_WIDTH'(AMIN);
        lane_sat[i] = 1'b1;
      end else begin
        acc_nxt[i]  = ACC_WIDTH'(lane_sum[i]);
        lane_sat[i] = 1'b0;
      end
    end
  end

  // Accumulators; magnitudes are taken as they are cleared at group close.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= '0;
      end
    end else if (cmd.accum) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
    end else if (cmd.mag) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      for (int i = 0; i < 4; i++) begin
        mag_r[i] <= acc_r[i][ACC_WIDTH-1] ? ACC_WIDTH'(-acc_r[i]) : ACC_WIDTH'(acc_r[i]);
      end
    end
  end

  // Partial product select: bits 3:2 pick the accumulator, bits 1:0 the halves.
  assign mag_sel = mag_r[cnt_r[3:2]];
  assign half_a  = cnt_r[0] ? HALF_W'(mag_sel >> HALF_W) : mag_sel[HALF_W-1:0];
  assign half_b  = cnt_r[1] ? HALF_W'(mag_sel >> HALF_W) : mag_sel[HALF_W-1:0];
  assign mul_w   = half_a * half_b;

  always_comb begin
    case (sh_r)
      gcna_pkg::SH_NONE: shifted = NORM_W'(prod_r);
      gcna_pkg::SH_HALF: shifted = NORM_W'(prod_r) << HALF_W;
      gcna_pkg::SH_FULL: shifted = NORM_W'(prod_r) << (2 * HALF_W);
      default:           shifted = '0;
    endcase
  end

  // Shared multiplier stage, then the running sum of squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.mag) begin
      pv_r  <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.sq_step) begin
      if (cnt_r != CNT_W'(gcna_pkg::SQ_STEPS)) begin
        pv_r  <= 1'b1;
        cnt_r <= cnt_r + 1'b1;
      end else begin
        pv_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_step) begin
      prod_r <= mul_w;
      sh_r   <= 2'(cnt_r[0]) + 2'(cnt_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      sum_r <= '0;
    end else if (cmd.sq_step && pv_r) begin
      sum_r <= sum_r + shifted;
    end
  end

  // Group norm added to the cell total with saturation.
  assign tot_w     = TW'(total_r) + TW'(sum_r >> FRAC);
  assign tot_sat   = tot_w > TMAX;
  assign total_new = tot_sat ? SUM_W'(TMAX) : SUM_W'(tot_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      sat_r   <= 1'b0;
    end else if (cmd.accum) begin
      sat_r <= sat_r | (|lane_sat);
    end else if (cmd.total) begin
      if (cend_r) begin
        total_r <= '0;
        sat_r   <= 1'b0;
      end else begin
        total_r <= total_new;
        sat_r   <= sat_r | tot_sat;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.total && cend_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.total && cend_r) begin
      out_sum_r <= total_new;
      out_ovf_r <= sat_r | tot_sat;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cell_sum = out_sum_r;
  assign out_overflow = out_ovf_r;

  assign stat.close_grp = close_r;
  assign stat.cell_end  = cend_r;
  assign stat.sq_done   = (cnt_r == CNT_W'(gcna_pkg::SQ_STEPS));
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

### rtl/grouped_complex_norm_accumulator.sv
// Top level of the grouped complex norm accumulator.
// Joins gcna_ctrl and gcna_dp; parameters default from gcna_pkg.
//
//   Channel  Handshake              Contents
//   in       in_valid / in_ready    den, theta, phi terms, group_end, cell_end
//   out      out_valid / out_ready  out_cell_sum, out_overflow
//
// A term that does not close its group is accepted, then accumulated. A group close
// then adds magnitude capture, the pass through the one shared 32x32 squaring
// multiplier (16 partial products), and the total update.
// Synchronous active-low reset clears the accumulators, cell total and flags.
// A cell end waits in the total update while the output register is still full.
`timescale 1ns / 1ps

module grouped_complex_norm_accumulator #(
  parameter int SAMPLE_WIDTH = gcna_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = gcna_pkg::ACC_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_den_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_den_im,
  input  logic signed [SAMPLE_WIDTH-1:0] in_theta_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_theta_im,
  input  logic signed [SAMPLE_WIDTH-1:0] in_phi_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_phi_im,
  input  logic                           in_group_end,
  input  logic                           in_cell_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gcna_pkg::SUM_W-1:0]     out_cell_sum,
  output logic                           out_overflow
);

  gcna_pkg::gcna_cmd_t  cmd;
  gcna_pkg::gcna_stat_t stat;

  // Controller.
  gcna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  gcna_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .den_re       (in_den_re),
    .den_im       (in_den_im),
    .theta_re     (in_theta_re),
    .theta_im     (in_theta_im),
    .phi_re       (in_phi_re),
    .phi_im       (in_phi_im),
    .group_end    (in_group_end),
    .cell_end     (in_cell_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cell_sum (out_cell_sum),
    .out_overflow (out_overflow)
  );

endmodule

### rtl/gcna_checker.sv
// Port-level checker for the grouped complex norm accumulator, bound to the top level.
// Watches only the top-level ports; uses gcna_pkg for the result width.
`timescale 1ns / 1ps

module gcna_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_group_end,
  input logic                       in_cell_end,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gcna_pkg::SUM_W-1:0] out_cell_sum,
  input logic                       out_overflow
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_sum) && $stable(out_overflow))
    else $error("result changed while stalled");

  // One request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in work");

  // A term inside a group is done after the accumulate cycle.
  a_plain_term: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_group_end && !in_cell_end |-> ##2 in_ready)
    else $error("plain term did not return to ready");

  // A group close keeps the block busy into the squaring sequence.
  a_group_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_group_end || in_cell_end) |-> ##2 !in_ready ##1 !in_ready)
    else $error("group close did not run the squaring sequence");

endmodule

bind grouped_complex_norm_accumulator gcna_checker u_gcna_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_group_end (in_group_end),
  .in_cell_end  (in_cell_end),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_cell_sum (out_cell_sum),
  .out_overflow (out_overflow)
);
